[hdl/ota_data_frame_builder_core_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the framed packet builder
// Shared helpers for clocked implication checks with synchronous reset.
// ----------------------------------------------------------------------------
`ifndef OTA_DATA_FRAME_BUILDER_CORE_MACROS_SVH
`define OTA_DATA_FRAME_BUILDER_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset
`define ODFB_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define ODFB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/odfb_pkg.sv]
// ----------------------------------------------------------------------------
// odfb_pkg
// Types, constants and the CRC-32/MPEG-2 byte update for the packet builder.
// ----------------------------------------------------------------------------
package odfb_pkg;

    localparam int unsigned LEN_W           = 11;
    localparam int unsigned LEN_MAX         = (1 << LEN_W) - 1;
    localparam int unsigned MAX_PAYLOAD_DEF = 1024;

    localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    localparam logic [7:0]  START_BYTE_RST = 8'hAA;
    localparam logic [7:0]  END_BYTE_RST   = 8'hBB;
    localparam logic [7:0]  FRAME_TYPE_RST = 8'h01;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_START_BYTE = 2'd0,
        CFG_END_BYTE   = 2'd1,
        CFG_FRAME_TYPE = 2'd2,
        CFG_CRC_SEED   = 2'd3
    } t_cfg_idx;

    // Byte slots of one item's output run
    typedef logic [3:0] t_slot;
    localparam t_slot SLOT_START  = 4'd0;
    localparam t_slot SLOT_TYPE   = 4'd1;
    localparam t_slot SLOT_LEN_LO = 4'd2;
    localparam t_slot SLOT_LEN_HI = 4'd3;
    localparam t_slot SLOT_DATA   = 4'd4;
    localparam t_slot SLOT_CRC_0  = 4'd5;
    localparam t_slot SLOT_CRC_1  = 4'd6;
    localparam t_slot SLOT_CRC_2  = 4'd7;
    localparam t_slot SLOT_CRC_3  = 4'd8;
    localparam t_slot SLOT_END    = 4'd9;

    typedef struct packed {
        logic [7:0]       payload_byte;
        logic [LEN_W-1:0] payload_len;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
        logic       run_last;
    } t_out_beat;

    typedef struct packed {
        logic [7:0]  start_byte;
        logic [7:0]  end_byte;
        logic [7:0]  frame_type;
        logic [31:0] crc_seed;
    } t_cfg;

    // Everything the serializer needs to emit one item's bytes
    typedef struct packed {
        logic             hdr;
        logic             tail;
        logic [7:0]       data;
        logic [LEN_W-1:0] len;
        logic [31:0]      crc;
    } t_bundle;

    typedef struct packed {
        logic load;
        logic free;
    } t_ser_ctl;

    // MSB-first CRC update over one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  b);
        logic [31:0] c;
        c = crc_in ^ {b, 24'h0};
        for (int k = 0; k < 8; k++) begin
            if (c[31]) begin
                c = {c[30:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[30:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

[hdl/ota_data_frame_builder_core.sv]
// ----------------------------------------------------------------------------
// ota_data_frame_builder_core
// Framed packet builder: header, payload echo, CRC-32/MPEG-2 trailer, end byte.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake               | beat
//  ----------+-----------+-------------------------+-------------------------
//  in        | to core   | i_valid / o_stall       | t_in_beat  (byte, length)
//  out       | from core | o_valid / i_stall       | t_out_beat (byte, flags)
//  cfg       | to core   | i_cfg_valid/o_cfg_ready | index 2b, data 32b
//
//  An input beat's CRC update and frame count finish in the cycle it is
//  taken. Its output bytes then leave one per cycle, while i_stall is low,
//  from the byte serializer: 1 mid-frame, 5 on a frame's first byte, 6 on
//  its last, 10 for a one-byte frame. A new input beat is taken in the
//  cycle the serializer sends its last byte, so mid-frame the core runs
//  one beat per cycle when unstalled. Synchronous reset returns the control
//  and config registers to defaults; the config port is always ready.
// ----------------------------------------------------------------------------
module ota_data_frame_builder_core
    import odfb_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_in_beat    i_in_beat,
    output logic        o_valid,
    input  logic        i_stall,
    output t_out_beat   o_out_beat,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    t_cfg     r_cfg;
    t_bundle  bundle;
    t_ser_ctl ser_ctl;
    logic     in_fire;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_byte <= START_BYTE_RST;
            r_cfg.end_byte   <= END_BYTE_RST;
            r_cfg.frame_type <= FRAME_TYPE_RST;
            r_cfg.crc_seed   <= CRC_INIT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_START_BYTE: r_cfg.start_byte <= i_cfg_data[7:0];
                CFG_END_BYTE:   r_cfg.end_byte   <= i_cfg_data[7:0];
                CFG_FRAME_TYPE: r_cfg.frame_type <= i_cfg_data[7:0];
                CFG_CRC_SEED:   r_cfg.crc_seed   <= i_cfg_data;
                default:        r_cfg.crc_seed   <= r_cfg.crc_seed;
            endcase
        end
    end

    assign o_stall = !ser_ctl.free;
    assign in_fire = i_valid && ser_ctl.free;

    odfb_frame_ctl #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_frame_ctl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (in_fire),
        .i_beat     (i_in_beat),
        .i_crc_seed (r_cfg.crc_seed),
        .o_bundle   (bundle)
    );

    odfb_byte_ser u_byte_ser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (in_fire),
        .i_bundle   (bundle),
        .i_cfg      (r_cfg),
        .i_stall    (i_stall),
        .o_valid    (o_valid),
        .o_out_beat (o_out_beat),
        .o_ctl      (ser_ctl)
    );

endmodule

[hdl/odfb_frame_ctl.sv]
// ----------------------------------------------------------------------------
// odfb_frame_ctl
// Frame position, sampled length and running CRC; builds one bundle per beat.
// ----------------------------------------------------------------------------
module odfb_frame_ctl
    import odfb_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_fire,
    input  t_in_beat    i_beat,
    input  logic [31:0] i_crc_seed,
    output t_bundle     o_bundle
);

    localparam int unsigned MaxClip = (MAX_PAYLOAD > LEN_MAX) ? LEN_MAX : MAX_PAYLOAD;
    localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MaxClip);

    logic [LEN_W-1:0] r_bytes_seen, n_bytes_seen;
    logic [LEN_W-1:0] r_frame_length, n_frame_length;
    logic [31:0]      r_crc, n_crc;

    logic             first;
    logic [LEN_W-1:0] len_clip;
    logic [LEN_W:0]   seen_inc;
    logic             tail;

    assign first = (r_bytes_seen == '0);

    always_comb begin
        if (i_beat.payload_len == '0) begin
            len_clip = LEN_W'(1);
        end else if (32'(i_beat.payload_len) > MaxClip) begin
            len_clip = MaxLen;
        end else begin
            len_clip = i_beat.payload_len;
        end
    end

    assign n_frame_length = first ? len_clip : r_frame_length;
    assign n_crc          = crc_byte(first ? i_crc_seed : r_crc, i_beat.payload_byte);
    assign seen_inc       = {1'b0, r_bytes_seen} + (LEN_W + 1)'(1);
    assign tail           = (seen_inc >= {1'b0, n_frame_length});
    assign n_bytes_seen   = tail ? '0 : seen_inc[LEN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_seen   <= '0;
            r_frame_length <= '0;
            r_crc          <= CRC_INIT;
        end else if (i_fire) begin
            r_bytes_seen   <= n_bytes_seen;
            r_frame_length <= n_frame_length;
            r_crc          <= n_crc;
        end
    end

    always_comb begin
        o_bundle.hdr  = first;
        o_bundle.tail = tail;
        o_bundle.data = i_beat.payload_byte;
        o_bundle.len  = n_frame_length;
        o_bundle.crc  = n_crc;
    end

endmodule

[hdl/odfb_byte_ser.sv]
// ----------------------------------------------------------------------------
// odfb_byte_ser
// Holds one bundle and walks its byte slots out, one beat per cycle unless stalled.
// ----------------------------------------------------------------------------
module odfb_byte_ser
    import odfb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_bundle   i_bundle,
    input  t_cfg      i_cfg,
    input  logic      i_stall,
    output logic      o_valid,
    output t_out_beat o_out_beat,
    output t_ser_ctl  o_ctl
);

    t_bundle r_bundle;
    t_slot   r_idx;
    logic    r_valid;

    t_slot last_idx;
    logic  out_fire;
    logic  at_last;

    assign last_idx = r_bundle.tail ? SLOT_END : SLOT_DATA;
    assign at_last  = (r_idx == last_idx);
    assign out_fire = r_valid && !i_stall;

    // Free when empty or when the last beat of the run leaves this cycle
    assign o_ctl.free = !r_valid || (out_fire && at_last);
    assign o_ctl.load = i_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= SLOT_DATA;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= i_bundle.hdr ? SLOT_START : SLOT_DATA;
        end else if (out_fire) begin
            if (at_last) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + t_slot'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bundle <= i_bundle;
        end
    end

    always_comb begin
        case (r_idx)
            SLOT_START:  o_out_beat.out_byte = i_cfg.start_byte;
            SLOT_TYPE:   o_out_beat.out_byte = i_cfg.frame_type;
            SLOT_LEN_LO: o_out_beat.out_byte = r_bundle.len[7:0];
            SLOT_LEN_HI: o_out_beat.out_byte = 8'(r_bundle.len[LEN_W-1:8]);
            SLOT_DATA:   o_out_beat.out_byte = r_bundle.data;
            SLOT_CRC_0:  o_out_beat.out_byte = r_bundle.crc[7:0];
            SLOT_CRC_1:  o_out_beat.out_byte = r_bundle.crc[15:8];
            SLOT_CRC_2:  o_out_beat.out_byte = r_bundle.crc[23:16];
            SLOT_CRC_3:  o_out_beat.out_byte = r_bundle.crc[31:24];
            SLOT_END:    o_out_beat.out_byte = i_cfg.end_byte;
            default:     o_out_beat.out_byte = r_bundle.data;
        endcase
        o_out_beat.frame_end = (r_idx == SLOT_END);
        o_out_beat.run_last  = at_last;
    end

    assign o_valid = r_valid;

endmodule

[hdl/odfb_checker.sv]
// ----------------------------------------------------------------------------
// odfb_checker
// Port-level checks on the packet builder, bound to the top level.
// ----------------------------------------------------------------------------
`include "ota_data_frame_builder_core_macros.svh"

module odfb_checker
    import odfb_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input t_in_beat    i_in_beat,
    input logic        o_valid,
    input logic        i_stall,
    input t_out_beat   o_out_beat,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic [1:0]  i_cfg_index,
    input logic [31:0] i_cfg_data
);

    // hold a stalled output beat
    `ODFB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_out_beat), "stalled output beat changed")

    // the end byte always closes its run
    `ODFB_ASSERT_SAME(a_end_is_last, i_clk, i_rst_n, o_valid && o_out_beat.frame_end, o_out_beat.run_last, "end byte not last of run")

    // a run never breaks off before its last beat
    `ODFB_ASSERT_NEXT(a_run_cont, i_clk, i_rst_n, o_valid && !i_stall && !o_out_beat.run_last, o_valid, "output run broke off early")

    // no new input while a run still has more beats to send
    `ODFB_ASSERT_SAME(a_in_blocked, i_clk, i_rst_n, o_valid && !o_out_beat.run_last, o_stall, "input taken mid-run")

endmodule

bind ota_data_frame_builder_core odfb_checker u_odfb_checker (.*);

[test/ota_data_frame_builder_core_tb.sv]
// ----------------------------------------------------------------------------
// ota_data_frame_builder_core_tb
// Self-checking bench for the framed packet builder. Payload beats go in with
// random gaps and the output side stalls at random. A scoreboard class
// predicts each beat's byte run: the header, the echoed payload byte, the
// CRC-32/MPEG-2 trailer and the end byte. Each output beat is checked in
// order against that prediction. Phases run at the reset values, then at
// the extremes and random values, reprogrammed between phases. One long
// receiver hold-off fills the core so that it stalls its input.
// ----------------------------------------------------------------------------
module ota_data_frame_builder_core_tb;
    import odfb_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 300;
    localparam int DRAIN_CYCLES   = 20;

    class packet_scoreboard;
        t_cfg             regs;
        logic [LEN_W-1:0] bytes_seen;
        logic [LEN_W-1:0] frame_len;
        logic [31:0]      running_crc;
        t_out_beat        pending_bytes[$];
        int               errors;
        int               beats_checked;

        function new();
            regs.start_byte = START_BYTE_RST;
            regs.end_byte   = END_BYTE_RST;
            regs.frame_type = FRAME_TYPE_RST;
            regs.crc_seed   = CRC_INIT;
            bytes_seen      = '0;
            frame_len       = '0;
            running_crc     = CRC_INIT;
            errors          = 0;
            beats_checked   = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [31:0] d);
            case (idx)
                CFG_START_BYTE: regs.start_byte = d[7:0];
                CFG_END_BYTE:   regs.end_byte   = d[7:0];
                CFG_FRAME_TYPE: regs.frame_type = d[7:0];
                CFG_CRC_SEED:   regs.crc_seed   = d;
                default: ;
            endcase
        endfunction

        // Shift one byte in MSB first, feeding back the polynomial on each carry
        function logic [31:0] crc_fold(logic [31:0] c, logic [7:0] d);
            logic fb;
            for (int k = 7; k >= 0; k--) begin
                fb = c[31] ^ d[k];
                c  = {c[30:0], 1'b0};
                if (fb) begin
                    c = c ^ CRC_POLY;
                end
            end
            return c;
        endfunction

        function t_out_beat out_of(logic [7:0] b, logic is_end);
            t_out_beat r;
            r.out_byte  = b;
            r.frame_end = is_end;
            r.run_last  = 1'b0;
            return r;
        endfunction

        function void note_input(t_in_beat b);
            t_out_beat        run[$];
            logic [LEN_W-1:0] len;
            if (bytes_seen == 0) begin
                len = b.payload_len;
                if (len == 0) begin
                    len = LEN_W'(1);
                end
                if (len > MAX_PAYLOAD_DEF) begin
                    len = LEN_W'(MAX_PAYLOAD_DEF);
                end
                frame_len   = len;
                running_crc = regs.crc_seed;
                run.push_back(out_of(regs.start_byte, 1'b0));
                run.push_back(out_of(regs.frame_type, 1'b0));
                run.push_back(out_of(len[7:0], 1'b0));
                run.push_back(out_of({5'b0, len[10:8]}, 1'b0));
            end
            run.push_back(out_of(b.payload_byte, 1'b0));
            running_crc = crc_fold(running_crc, b.payload_byte);
            bytes_seen  = bytes_seen + 1'b1;
            if (bytes_seen >= frame_len) begin
                for (int k = 0; k < 4; k++) begin
                    run.push_back(out_of(running_crc[8*k +: 8], 1'b0));
                end
                run.push_back(out_of(regs.end_byte, 1'b1));
                bytes_seen = '0;
            end
            run[run.size()-1].run_last = 1'b1;
            foreach (run[i]) begin
                pending_bytes.push_back(run[i]);
            end
        endfunction

        function int pending();
            return pending_bytes.size();
        endfunction

        task report(string what);
            errors++;
            $display("mismatch at output beat %0d: %s", beats_checked, what);
        endtask

        task check_result(t_out_beat got);
            t_out_beat want;
            beats_checked++;
            if (pending_bytes.size() == 0) begin
                report($sformatf("unexpected beat, byte %02h", got.out_byte));
                return;
            end
            want = pending_bytes.pop_front();
            if (got.out_byte !== want.out_byte) begin
                report($sformatf("out_byte %02h, want %02h", got.out_byte, want.out_byte));
            end
            if (got.frame_end !== want.frame_end) begin
                report($sformatf("frame_end %b, want %b", got.frame_end, want.frame_end));
            end
            if (got.run_last !== want.run_last) begin
                report($sformatf("run_last %b, want %b", got.run_last, want.run_last));
            end
        endtask
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    t_in_beat    i_in_beat   = '0;
    logic        i_stall     = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data  = '0;
    logic        o_stall;
    logic        o_valid;
    logic        o_cfg_ready;
    t_out_beat   o_out_beat;

    packet_scoreboard sb;
    int               idle_pct  = 0;
    int               stall_pct = 0;
    bit               hold_req  = 1'b0;
    int               items_sent = 0;
    int               quiet_cycles = 0;

    ota_data_frame_builder_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_in_beat   (i_in_beat),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_beat  (o_out_beat),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    function t_in_beat beat(logic [7:0] d, logic [LEN_W-1:0] len);
        t_in_beat b;
        b.payload_byte = d;
        b.payload_len  = len;
        return b;
    endfunction

    function logic [7:0] pick_byte();
        int r;
        r = $urandom_range(99);
        if (r < 20) begin
            return 8'h00;
        end else if (r < 40) begin
            return 8'hFF;
        end
        return 8'($urandom_range(255));
    endfunction

    function logic [31:0] pick_seed();
        int r;
        r = $urandom_range(99);
        if (r < 20) begin
            return 32'h0000_0000;
        end else if (r < 40) begin
            return 32'hFFFF_FFFF;
        end
        return $urandom;
    endfunction

    // Mostly short frames so many frame boundaries go by
    function logic [LEN_W-1:0] pick_len();
        int r;
        r = $urandom_range(99);
        if (r < 5) begin
            return '0;
        end else if (r < 70) begin
            return LEN_W'($urandom_range(1, 4));
        end else if (r < 90) begin
            return LEN_W'($urandom_range(5, 16));
        end
        return LEN_W'($urandom_range(17, 40));
    endfunction

    task send_beat(t_in_beat b);
        if ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_beat <= b;
        do @(posedge i_clk); while (o_stall);
        sb.note_input(b);
        items_sent++;
    endtask

    // Length field is random on every beat after the first
    task send_frame(logic [LEN_W-1:0] len_field);
        int n;
        n = (len_field == 0) ? 1 : (len_field > MAX_PAYLOAD_DEF) ? MAX_PAYLOAD_DEF : len_field;
        send_beat(beat(8'($urandom_range(255)), len_field));
        for (int i = 1; i < n; i++) begin
            send_beat(beat(8'($urandom_range(255)), LEN_W'($urandom_range(2047))));
        end
    endtask

    task run_frames(int n_items);
        int first;
        first = items_sent;
        while (items_sent - first < n_items) begin
            send_frame(pick_len());
        end
    endtask

    // Drop valid and wait for the core to drain before touching registers
    task drain();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task write_reg(t_cfg_idx idx, logic [31:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, d);
    endtask

    task program_regs(logic [7:0] sb_val, logic [7:0] eb_val, logic [7:0] ft_val,
                      logic [31:0] seed);
        write_reg(CFG_START_BYTE, {24'h0, sb_val});
        write_reg(CFG_END_BYTE,   {24'h0, eb_val});
        write_reg(CFG_FRAME_TYPE, {24'h0, ft_val});
        write_reg(CFG_CRC_SEED,   seed);
        i_cfg_valid <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_result(o_out_beat);
        end
    end

    initial begin
        int burst;
        burst = 0;
        forever begin
            @(posedge i_clk);
            if (burst > 0) begin
                burst--;
            end else if (hold_req) begin
                hold_req = 1'b0;
                burst    = LONG_HOLD - 1;
                i_stall <= 1'b1;
            end else if ($urandom_range(99) < stall_pct) begin
                burst    = $urandom_range(1, 11) - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("ota_data_frame_builder_core_tb NOT OK");
            $finish;
        end
    end

    initial begin
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset register values: one-byte frame, zero length, length ignored mid-frame
        idle_pct  = 20;
        stall_pct = 20;
        send_beat(beat(8'h00, 11'd1));
        send_beat(beat(8'hFF, 11'd0));
        send_beat(beat(8'h80, 11'd3));
        send_beat(beat(8'h01, 11'd0));
        send_beat(beat(8'h7F, 11'h7FF));
        send_beat(beat(8'hA5, 11'd2));
        send_beat(beat(8'h5A, 11'd1));
        drain();

        program_regs(8'h00, 8'hFF, 8'hFF, 32'h0000_0000);
        send_beat(beat(8'hFF, 11'd1));
        send_beat(beat(8'h00, 11'd2));
        send_beat(beat(8'hFF, 11'h7FF));
        drain();

        program_regs(8'hFF, 8'h00, 8'h00, 32'hFFFF_FFFF);
        send_beat(beat(8'h12, 11'd4));
        send_beat(beat(8'h34, 11'd0));
        send_beat(beat(8'h56, 11'd5));
        send_beat(beat(8'h78, 11'd1));
        drain();

        idle_pct  = 30;
        stall_pct = 30;
        program_regs(pick_byte(), pick_byte(), pick_byte(), pick_seed());
        run_frames(80);
        drain();

        // Hold the output long enough for the core to back up its input
        idle_pct  = 5;
        stall_pct = 10;
        program_regs(pick_byte(), pick_byte(), pick_byte(), pick_seed());
        hold_req = 1'b1;
        run_frames(80);
        drain();

        idle_pct  = 45;
        stall_pct = 45;
        program_regs(pick_byte(), pick_byte(), pick_byte(), pick_seed());
        run_frames(75);
        drain();

        idle_pct  = 0;
        stall_pct = 0;
        program_regs(pick_byte(), pick_byte(), pick_byte(), pick_seed());
        run_frames(75);
        drain();

        // Open an oversize frame: its header carries the saturated length
        send_beat(beat(pick_byte(), 11'h7FF));
        drain();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("ota_data_frame_builder_core_tb OK");
        end else begin
            $display("ota_data_frame_builder_core_tb NOT OK");
        end
        $finish;
    end

endmodule
